// ===== sv/lpe_pkg.sv =====
// Package for the Lagrange polynomial evaluator.
// Holds sizes, opcodes, status codes and the command and result structs.
// No dependencies.
package lpe_pkg;

    localparam int MAX_POINTS = 8;
    localparam int FRAC_BITS  = 16;

    localparam int DATA_W = 32;
    localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int DIFF_W = DATA_W + 1;
    localparam int NUM_W  = DIFF_W + FRAC_BITS;
    localparam int REM_W  = DIFF_W + 1;
    localparam int STEP_W = $clog2(NUM_W + 1);

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_EVAL   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_COINC = 2'd1;
    localparam logic [1:0] ST_OVF   = 2'd2;

    typedef struct packed {
        logic        [1:0]        opcode;
        logic signed [DATA_W-1:0] x_value;
        logic signed [DATA_W-1:0] y_value;
    } t_cmd;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic        [1:0]        status;
    } t_result;

endpackage

// ===== sv/lagrange_poly_eval.sv =====
// Lagrange polynomial evaluator top level.
// Point store, pair check, shared restoring divider, multiplier and accumulator.
// Depends on lpe_pkg.
//
// Usage: drive i_cmd and raise start; the command transfers on a clock edge
// with start high and busy low. Clear and load leave busy low and give no
// result. Loads beyond the store capacity are dropped. An evaluate runs the
// sequencer: a coincidence scan over all point pairs, ending early on a match,
// then for each ordered pair (i, j != i) one quotient on the shared restoring
// divider (NUM_W = 49 steps, one quotient bit per cycle) followed by a
// saturate, a multiply and a rescale. The result is shown on o_result for one
// cycle with o_done high; the receiver cannot stall it and must take it then.
// An empty store answers 0 with status ok without running the sequencer.
// Reset empties the store and returns the sequencer to idle; stored
// coordinates are not cleared.
module lagrange_poly_eval (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  lpe_pkg::t_cmd   i_cmd,
    output logic            busy,
    output logic            o_done,
    output lpe_pkg::t_result o_result
);

    typedef enum logic [3:0] {
        S_IDLE, S_CK_I, S_CK_IW, S_CK_IL, S_CK_JW, S_CK_JC,
        S_EV_I, S_EV_IW, S_EV_IL, S_EV_J, S_EV_JW, S_EV_JL,
        S_EV_DIV, S_EV_QS, S_EV_MUL, S_EV_SH
    } t_state;

    typedef struct packed {
        logic                            ovf;
        logic signed [lpe_pkg::DATA_W-1:0] val;
    } t_sat;

    function automatic t_sat sat32(input logic signed [63:0] v);
        t_sat s;
        s.ovf = 1'b0;
        s.val = v[lpe_pkg::DATA_W-1:0];
        if (v > 64'sd2147483647) begin
            s.ovf = 1'b1;
            s.val = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            s.ovf = 1'b1;
            s.val = 32'sh80000000;
        end
        return s;
    endfunction

    logic signed [lpe_pkg::DATA_W-1:0] mem_x [lpe_pkg::MAX_POINTS];
    logic signed [lpe_pkg::DATA_W-1:0] mem_y [lpe_pkg::MAX_POINTS];

    t_state                              r_state;
    logic [lpe_pkg::CNT_W-1:0]           r_count;
    logic [lpe_pkg::CNT_W-1:0]           r_i;
    logic [lpe_pkg::CNT_W-1:0]           r_j;
    logic [lpe_pkg::IDX_W-1:0]           r_addr;
    logic signed [lpe_pkg::DATA_W-1:0]   r_rd_x;
    logic signed [lpe_pkg::DATA_W-1:0]   r_rd_y;
    logic signed [lpe_pkg::DATA_W-1:0]   r_x;
    logic signed [lpe_pkg::DATA_W-1:0]   r_xi;
    logic signed [lpe_pkg::DATA_W-1:0]   r_term;
    logic signed [lpe_pkg::DATA_W-1:0]   r_q;
    logic signed [lpe_pkg::DATA_W-1:0]   r_sum;
    logic signed [63:0]                  r_prod;
    logic [lpe_pkg::NUM_W-1:0]           r_quo;
    logic [lpe_pkg::REM_W-1:0]           r_rem;
    logic [lpe_pkg::DIFF_W-1:0]          r_den;
    logic [lpe_pkg::STEP_W-1:0]          r_step;
    logic                                r_qneg;
    logic                                r_ovf;

    logic                                wr_en;
    logic signed [lpe_pkg::DIFF_W-1:0]   dx;
    logic signed [lpe_pkg::DIFF_W-1:0]   dd;
    logic [lpe_pkg::DIFF_W-1:0]          dx_mag;
    logic [lpe_pkg::DIFF_W-1:0]          dd_mag;
    logic [lpe_pkg::REM_W-1:0]           rem_sh;
    logic [lpe_pkg::REM_W:0]             rem_sub;
    logic signed [lpe_pkg::NUM_W:0]      q_signed;
    logic signed [63:0]                  prod_bias;
    logic signed [63:0]                  sum_wide;
    t_sat                                q_sat;
    t_sat                                term_sat;
    t_sat                                s_sat;

    assign busy  = (r_state != S_IDLE);
    assign wr_en = start && !busy && (i_cmd.opcode == lpe_pkg::OP_LOAD)
                   && (r_count < lpe_pkg::CNT_W'(lpe_pkg::MAX_POINTS));

    always_comb begin
        dx      = lpe_pkg::DIFF_W'(r_x) - lpe_pkg::DIFF_W'(r_rd_x);
        dd      = lpe_pkg::DIFF_W'(r_xi) - lpe_pkg::DIFF_W'(r_rd_x);
        dx_mag  = dx[lpe_pkg::DIFF_W-1] ? lpe_pkg::DIFF_W'(-dx) : lpe_pkg::DIFF_W'(dx);
        dd_mag  = dd[lpe_pkg::DIFF_W-1] ? lpe_pkg::DIFF_W'(-dd) : lpe_pkg::DIFF_W'(dd);
        rem_sh  = {r_rem[lpe_pkg::REM_W-2:0], r_quo[lpe_pkg::NUM_W-1]};
        rem_sub = {1'b0, rem_sh} - {2'b00, r_den};
        q_signed = r_qneg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
        q_sat   = sat32(64'(q_signed));
        prod_bias = r_prod + (r_prod[63] ? 64'((64'sd1 <<< lpe_pkg::FRAC_BITS) - 64'sd1)
                                         : 64'sd0);
        term_sat = sat32(prod_bias >>> lpe_pkg::FRAC_BITS);
        sum_wide = 64'(r_sum) + 64'(r_term);
        s_sat   = sat32(sum_wide);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_x[r_count[lpe_pkg::IDX_W-1:0]] <= i_cmd.x_value;
            mem_y[r_count[lpe_pkg::IDX_W-1:0]] <= i_cmd.y_value;
        end
        r_rd_x <= mem_x[r_addr];
        r_rd_y <= mem_y[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        case (i_cmd.opcode)
                            lpe_pkg::OP_CLEAR: r_count <= '0;
                            lpe_pkg::OP_LOAD: begin
                                if (wr_en) r_count <= r_count + 1'b1;
                            end
                            lpe_pkg::OP_EVAL: begin
                                r_x   <= i_cmd.x_value;
                                r_i   <= '0;
                                r_sum <= '0;
                                r_ovf <= 1'b0;
                                if (r_count == '0) begin
                                    o_done                <= 1'b1;
                                    o_result.result_value <= '0;
                                    o_result.status       <= lpe_pkg::ST_OK;
                                end else begin
                                    r_state <= S_CK_I;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_CK_I: begin
                    r_addr  <= r_i[lpe_pkg::IDX_W-1:0];
                    r_state <= S_CK_IW;
                end
                S_CK_IW: r_state <= S_CK_IL;
                S_CK_IL: begin
                    r_xi <= r_rd_x;
                    r_j  <= r_i + 1'b1;
                    if (r_i + 1'b1 >= r_count) begin
                        r_i     <= '0;
                        r_state <= S_EV_I;
                    end else begin
                        r_addr  <= lpe_pkg::IDX_W'(r_i + 1'b1);
                        r_state <= S_CK_JW;
                    end
                end
                S_CK_JW: r_state <= S_CK_JC;
                S_CK_JC: begin
                    if (r_rd_x == r_xi) begin
                        o_done                <= 1'b1;
                        o_result.result_value <= '0;
                        o_result.status       <= lpe_pkg::ST_COINC;
                        r_state               <= S_IDLE;
                    end else if (r_j + 1'b1 >= r_count) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_CK_I;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_addr  <= lpe_pkg::IDX_W'(r_j + 1'b1);
                        r_state <= S_CK_JW;
                    end
                end
                S_EV_I: begin
                    r_addr  <= r_i[lpe_pkg::IDX_W-1:0];
                    r_state <= S_EV_IW;
                end
                S_EV_IW: r_state <= S_EV_IL;
                S_EV_IL: begin
                    r_xi    <= r_rd_x;
                    r_term  <= r_rd_y;
                    r_j     <= '0;
                    r_state <= S_EV_J;
                end
                S_EV_J: begin
                    if (r_j == r_count) begin
                        r_sum <= s_sat.val;
                        r_ovf <= r_ovf | s_sat.ovf;
                        if (r_i + 1'b1 == r_count) begin
                            o_done                <= 1'b1;
                            o_result.result_value <= s_sat.val;
                            o_result.status       <= (r_ovf | s_sat.ovf) ? lpe_pkg::ST_OVF
                                                                         : lpe_pkg::ST_OK;
                            r_state               <= S_IDLE;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_EV_I;
                        end
                    end else if (r_j == r_i) begin
                        r_j <= r_j + 1'b1;
                    end else begin
                        r_addr  <= r_j[lpe_pkg::IDX_W-1:0];
                        r_state <= S_EV_JW;
                    end
                end
                S_EV_JW: r_state <= S_EV_JL;
                S_EV_JL: begin
                    r_quo   <= {dx_mag, {lpe_pkg::FRAC_BITS{1'b0}}};
                    r_rem   <= '0;
                    r_den   <= dd_mag;
                    r_qneg  <= dx[lpe_pkg::DIFF_W-1] ^ dd[lpe_pkg::DIFF_W-1];
                    r_step  <= '0;
                    r_state <= S_EV_DIV;
                end
                S_EV_DIV: begin
                    r_rem <= rem_sub[lpe_pkg::REM_W] ? rem_sh
                                                     : rem_sub[lpe_pkg::REM_W-1:0];
                    r_quo <= {r_quo[lpe_pkg::NUM_W-2:0], ~rem_sub[lpe_pkg::REM_W]};
                    r_step <= r_step + 1'b1;
                    if (r_step == lpe_pkg::STEP_W'(lpe_pkg::NUM_W - 1)) r_state <= S_EV_QS;
                end
                S_EV_QS: begin
                    r_q     <= q_sat.val;
                    r_ovf   <= r_ovf | q_sat.ovf;
                    r_state <= S_EV_MUL;
                end
                S_EV_MUL: begin
                    r_prod  <= r_term * r_q;
                    r_state <= S_EV_SH;
                end
                S_EV_SH: begin
                    r_term  <= term_sat.val;
                    r_ovf   <= r_ovf | term_sat.ovf;
                    r_j     <= r_j + 1'b1;
                    r_state <= S_EV_J;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= lpe_pkg::CNT_W'(lpe_pkg::MAX_POINTS))
        else $error("point count above capacity");

    a_coinc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_result.status == lpe_pkg::ST_COINC) |-> o_result.result_value == '0)
        else $error("coincident status with nonzero value");

    a_div_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EV_DIV) |-> r_step < lpe_pkg::STEP_W'(lpe_pkg::NUM_W))
        else $error("divider step count overrun");

    a_done_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_done) |-> $past(busy) || $past(start))
        else $error("result without a command");

endmodule

// ===== tb/tb_lagrange_poly_eval.sv =====
// Testbench for lagrange_poly_eval: clear, load and evaluate transfers checked
// against a fixed-point Lagrange predictor kept in the bench. Depends on lpe_pkg.
module tb_lagrange_poly_eval;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    lpe_pkg::t_cmd    i_cmd;
    logic             busy;
    logic             o_done;
    lpe_pkg::t_result o_result;

    lagrange_poly_eval dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_cmd(i_cmd),
        .busy(busy), .o_done(o_done), .o_result(o_result)
    );

    lpe_pkg::t_cmd    cmd_queue[$];
    lpe_pkg::t_result expected_results[$];
    int      idle_pct;
    bit      hold_off;
    int      fail_count;

    longint  pred_x[lpe_pkg::MAX_POINTS];
    longint  pred_y[lpe_pkg::MAX_POINTS];
    int      pred_count;

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic longint clamp32(longint v, inout bit ovf);
        if (v > 64'sd2147483647) begin
            ovf = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            ovf = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic lpe_pkg::t_result interpolate(longint xe);
        lpe_pkg::t_result r;
        longint sum, term, q;
        bit ovf;
        sum = 0;
        ovf = 1'b0;
        r.result_value = '0;
        r.status = lpe_pkg::ST_OK;
        for (int i = 0; i < pred_count; i++)
            for (int j = i + 1; j < pred_count; j++)
                if (pred_x[i] == pred_x[j]) begin
                    r.status = lpe_pkg::ST_COINC;
                    return r;
                end
        for (int i = 0; i < pred_count; i++) begin
            term = pred_y[i];
            for (int j = 0; j < pred_count; j++) begin
                if (j != i) begin
                    q = ((xe - pred_x[j]) * (64'sd1 <<< lpe_pkg::FRAC_BITS))
                        / (pred_x[i] - pred_x[j]);
                    q = clamp32(q, ovf);
                    term = clamp32((term * q) / (64'sd1 <<< lpe_pkg::FRAC_BITS), ovf);
                end
            end
            sum = clamp32(sum + term, ovf);
        end
        r.result_value = sum[31:0];
        r.status = ovf ? lpe_pkg::ST_OVF : lpe_pkg::ST_OK;
        return r;
    endfunction

    task automatic push_cmd(logic [1:0] op, logic [31:0] xv, logic [31:0] yv);
        lpe_pkg::t_cmd c;
        c.opcode = op;
        c.x_value = xv;
        c.y_value = yv;
        cmd_queue.push_back(c);
    endtask

    function automatic logic [31:0] rand_small();
        return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
    endfunction

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cmd <= '0;
        end else if (start && !busy) begin
            if (cmd_queue.size() > 0 && !hold_off &&
                $urandom_range(0, 99) >= idle_pct) begin
                i_cmd <= cmd_queue.pop_front();
            end else begin
                start <= 1'b0;
            end
        end else if (!start) begin
            if (cmd_queue.size() > 0 && !hold_off &&
                $urandom_range(0, 99) >= idle_pct) begin
                i_cmd <= cmd_queue.pop_front();
                start <= 1'b1;
            end
        end
    end

    // Predict on each accepted transfer, check each result strobe.
    always @(posedge i_clk) begin
        lpe_pkg::t_result e;
        if (i_rst_n) begin
            if (start && !busy) begin
                case (i_cmd.opcode)
                    lpe_pkg::OP_CLEAR: pred_count = 0;
                    lpe_pkg::OP_LOAD: begin
                        if (pred_count < lpe_pkg::MAX_POINTS) begin
                            pred_x[pred_count] = longint'(i_cmd.x_value);
                            pred_y[pred_count] = longint'(i_cmd.y_value);
                            pred_count++;
                        end
                    end
                    lpe_pkg::OP_EVAL:
                        expected_results.push_back(interpolate(longint'(i_cmd.x_value)));
                    default: ;
                endcase
            end
            if (o_done) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result %h", o_result);
                    fail_count++;
                end else begin
                    e = expected_results.pop_front();
                    if (o_result.result_value !== e.result_value) begin
                        $error("result_value expected %h actual %h",
                               e.result_value, o_result.result_value);
                        fail_count++;
                    end
                    if (o_result.status !== e.status) begin
                        $error("status expected %0d actual %0d", e.status, o_result.status);
                        fail_count++;
                    end
                end
            end
        end
    end

    task automatic drain();
        while (cmd_queue.size() > 0 || start || busy || expected_results.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        int n;
        i_rst_n = 1'b0;
        idle_pct = 0;
        hold_off = 1'b0;
        fail_count = 0;
        pred_count = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty store, unused opcode, field extremes, coincidence, full store.
        push_cmd(lpe_pkg::OP_EVAL, 32'h8000_0000, 32'h7fff_ffff);
        push_cmd(lpe_pkg::OP_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
        push_cmd(lpe_pkg::OP_LOAD, 32'h0001_0000, 32'h7fff_ffff);
        push_cmd(lpe_pkg::OP_EVAL, 32'h7fff_ffff, 32'h0);
        push_cmd(lpe_pkg::OP_LOAD, 32'h8000_0000, 32'h8000_0000);
        push_cmd(lpe_pkg::OP_EVAL, 32'h7fff_ffff, 32'hffff_ffff);
        push_cmd(lpe_pkg::OP_EVAL, 32'h0, 32'h0);
        push_cmd(lpe_pkg::OP_LOAD, 32'h0001_0000, 32'h0005_0000);
        push_cmd(lpe_pkg::OP_EVAL, 32'h0002_0000, 32'h0);
        push_cmd(lpe_pkg::OP_CLEAR, 32'hffff_ffff, 32'hffff_ffff);
        push_cmd(lpe_pkg::OP_EVAL, 32'h0003_0000, 32'h0);
        for (int k = 0; k < 9; k++)
            push_cmd(lpe_pkg::OP_LOAD, k << 16, (k * k) << 16);
        push_cmd(lpe_pkg::OP_EVAL, 32'h0002_8000, 32'h0);
        push_cmd(lpe_pkg::OP_EVAL, 32'h7fff_0000, 32'h0);
        push_cmd(lpe_pkg::OP_CLEAR, 32'h0, 32'h0);
        drain();

        // Hold a pending command back until every expected result has come.
        push_cmd(lpe_pkg::OP_LOAD, 32'h0000_0001, 32'h0000_0100);
        push_cmd(lpe_pkg::OP_LOAD, 32'h0000_0002, 32'h7fff_ffff);
        push_cmd(lpe_pkg::OP_EVAL, 32'h0000_0003, 32'h0);
        while (cmd_queue.size() > 0) @(posedge i_clk);
        hold_off = 1'b1;
        push_cmd(lpe_pkg::OP_EVAL, 32'h0000_0005, 32'h0);
        while (start || busy || expected_results.size() > 0) @(posedge i_clk);
        hold_off = 1'b0;
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = (phase == 0) ? 0 : (phase == 3) ? 6 : 86;
            for (int it = 0; it < 70; it++) begin
                n = $urandom_range(0, 99);
                if (n < 8) begin
                    push_cmd(lpe_pkg::OP_CLEAR, $urandom, $urandom);
                end else if (n < 11) begin
                    push_cmd(lpe_pkg::OP_UNUSED, $urandom, $urandom);
                end else if (n < 50) begin
                    if ($urandom_range(0, 9) == 0)
                        push_cmd(lpe_pkg::OP_LOAD, $urandom, $urandom);
                    else
                        push_cmd(lpe_pkg::OP_LOAD, rand_small(), rand_small());
                end else begin
                    if ($urandom_range(0, 4) == 0)
                        push_cmd(lpe_pkg::OP_EVAL, $urandom, $urandom);
                    else
                        push_cmd(lpe_pkg::OP_EVAL, rand_small(), $urandom);
                end
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #120000000;
        $display("status: fail");
        $finish;
    end
endmodule
